// ----- rtl/core/lut_distortion_correction_core_assert.svh -----
// Assertion macros for the distortion correction core checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LUT_DISTORTION_CORRECTION_CORE_ASSERT_SVH
`define LUT_DISTORTION_CORRECTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define LDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldc: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define LDC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ldc: reset check failed");

`endif

// ----- rtl/core/ldc_pkg.sv -----
// Shared widths, codes and the reciprocal table of the distortion correction core.
// No dependencies; used by the interfaces, the core and the checker.
package ldc_pkg;

    // Field widths
    localparam int COORD_W    = 19;
    localparam int SHIFT_W    = 16;
    localparam int INDEX_W    = 18;
    localparam int SCALE_W    = 5;
    localparam int FRAME_W    = 14;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // Table origin in whole pixels
    localparam int TABLE_ORIGIN = 44;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_CORRECTED = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FRAME     = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_TABLE     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_INVALID   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_WRITTEN   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER  = 3'd4;

    // Whole-pixel value before division: (c + 16 s) >> 5 fits 15 bits
    localparam int PIX_W = 15;

    // Reciprocal ceil(2^RS / s); exact for PIX_W-bit dividends and s < 32.
    // Entry 0 serves a scale of zero, which acts as one.
    localparam int RS      = 21;
    localparam int RECIP_W = RS + 1;
    localparam logic [RECIP_W-1:0] RECIP [32] = '{
        22'(2**RS),            22'(2**RS),            22'((2**RS + 1) / 2),
        22'((2**RS + 2) / 3),  22'((2**RS + 3) / 4),  22'((2**RS + 4) / 5),
        22'((2**RS + 5) / 6),  22'((2**RS + 6) / 7),  22'((2**RS + 7) / 8),
        22'((2**RS + 8) / 9),  22'((2**RS + 9) / 10), 22'((2**RS + 10) / 11),
        22'((2**RS + 11) / 12), 22'((2**RS + 12) / 13), 22'((2**RS + 13) / 14),
        22'((2**RS + 14) / 15), 22'((2**RS + 15) / 16), 22'((2**RS + 16) / 17),
        22'((2**RS + 17) / 18), 22'((2**RS + 18) / 19), 22'((2**RS + 19) / 20),
        22'((2**RS + 20) / 21), 22'((2**RS + 21) / 22), 22'((2**RS + 22) / 23),
        22'((2**RS + 23) / 24), 22'((2**RS + 24) / 25), 22'((2**RS + 25) / 26),
        22'((2**RS + 26) / 27), 22'((2**RS + 27) / 28), 22'((2**RS + 28) / 29),
        22'((2**RS + 29) / 30), 22'((2**RS + 30) / 31)
    };

endpackage

// ----- rtl/core/ldc_req_if.sv -----
// Request channel of the distortion correction core: point or table write.
// Depends on ldc_pkg for field widths.
interface ldc_req_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic        [ldc_pkg::COORD_W-1:0]  x_in;
    logic        [ldc_pkg::COORD_W-1:0]  y_in;
    logic        [ldc_pkg::INDEX_W-1:0]  entry_index;
    logic signed [ldc_pkg::SHIFT_W-1:0]  x_shift;
    logic signed [ldc_pkg::SHIFT_W-1:0]  y_shift;

    modport source (output valid, opcode, x_in, y_in, entry_index, x_shift, y_shift,
                    input ready);
    modport sink   (input valid, opcode, x_in, y_in, entry_index, x_shift, y_shift,
                    output ready);
endinterface

// ----- rtl/core/ldc_res_if.sv -----
// Result channel of the distortion correction core.
// Depends on ldc_pkg for field widths.
interface ldc_res_if;
    logic                               valid;
    logic                               ready;
    logic [ldc_pkg::COORD_W-1:0]        x_out;
    logic [ldc_pkg::COORD_W-1:0]        y_out;
    logic [ldc_pkg::OUTCOME_W-1:0]      outcome;

    modport source (output valid, x_out, y_out, outcome, input ready);
    modport sink   (input valid, x_out, y_out, outcome, output ready);
endinterface

// ----- rtl/core/lut_distortion_correction_core.sv -----
// Distortion correction core: scale, table lookup, offset and frame check.
// Depends on ldc_pkg, ldc_req_if and ldc_res_if.

// One request enters per clock; the rate is one item per cycle, set by the
// single-port offset table, which each item touches at most once (a read
// for a point, a write for a table load) in the fourth stage, so accesses
// stay in request order and need no forwarding. Scaling uses a reciprocal
// multiply, the offsets a small multiply by the scale. The whole pipeline
// holds while a result waits untaken. The table is TABLE_SIDE^2 words of
// 32 bits (x offset high, y offset low), has no clearing pass, and must be
// loaded before points that use an entry are sent. Configuration must be
// written only while idle; the core does not enforce this.
module lut_distortion_correction_core #(
    parameter int TABLE_SIDE = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ldc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ldc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ldc_req_if.sink                           i_req,
    ldc_res_if.source                         o_res
);

    localparam int DEPTH  = TABLE_SIDE * TABLE_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(TABLE_SIDE);
    localparam int MEM_W  = 2 * ldc_pkg::SHIFT_W;
    localparam int CW     = ldc_pkg::COORD_W;
    localparam int PW     = ldc_pkg::PIX_W;
    localparam int PRODW  = PW + ldc_pkg::RECIP_W;
    localparam int OFSW   = ldc_pkg::SHIFT_W + ldc_pkg::SCALE_W + 1;
    localparam int SUMW   = OFSW + 1;

    // Configuration registers
    logic [ldc_pkg::SCALE_W-1:0]  r_scale;
    logic [ldc_pkg::FRAME_W-1:0]  r_width;
    logic [ldc_pkg::FRAME_W-1:0]  r_height;
    logic                         r_check;
    logic [CW-1:0]                r_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 5'd1;
            r_width  <= 14'd600;
            r_height <= 14'd600;
            r_check  <= 1'b0;
            r_marker <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ldc_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[ldc_pkg::SCALE_W-1:0];
                ldc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[ldc_pkg::FRAME_W-1:0];
                ldc_pkg::CFG_HEIGHT: r_height <= i_cfg_data[ldc_pkg::FRAME_W-1:0];
                ldc_pkg::CFG_CHECK:  r_check  <= i_cfg_data[0];
                ldc_pkg::CFG_MARKER: r_marker <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Zero scale acts as one
    logic [ldc_pkg::SCALE_W-1:0] w_scale;
    assign w_scale = (r_scale == '0) ? 5'd1 : r_scale;

    // Global advance: hold everything while a result sits untaken
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    assign w_en        = !(r_v6 && !o_res.ready);
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6} <= '0;
        end else if (w_en) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Stage 1: invalid check, rounding offset and pixel truncation
    logic                r_op1, r_inv1, r_we1;
    logic [CW-1:0]       r_x1, r_y1;
    logic [PW-1:0]       r_mx1, r_my1;
    logic [AW-1:0]       r_wa1;
    logic [MEM_W-1:0]    r_wd1;
    logic [CW:0]         n_nx1, n_ny1;

    always_comb begin
        n_nx1 = {1'b0, i_req.x_in} + (CW + 1)'({w_scale, 4'b0});
        n_ny1 = {1'b0, i_req.y_in} + (CW + 1)'({w_scale, 4'b0});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1  <= i_req.opcode;
            r_x1   <= i_req.x_in;
            r_y1   <= i_req.y_in;
            r_inv1 <= r_check && (i_req.x_in == r_marker || i_req.y_in == r_marker);
            r_mx1  <= n_nx1[CW:5];
            r_my1  <= n_ny1[CW:5];
            r_we1  <= i_req.opcode && (32'(i_req.entry_index) < 32'(DEPTH));
            r_wa1  <= AW'(i_req.entry_index);
            r_wd1  <= {i_req.x_shift, i_req.y_shift};
        end
    end

    // Stage 2: reciprocal multiply for the scale division
    logic                r_op2, r_inv2, r_we2;
    logic [CW-1:0]       r_x2, r_y2;
    logic [PRODW-1:0]    r_px2, r_py2;
    logic [AW-1:0]       r_wa2;
    logic [MEM_W-1:0]    r_wd2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op2  <= r_op1;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_inv2 <= r_inv1;
            r_px2  <= PRODW'(r_mx1) * PRODW'(ldc_pkg::RECIP[r_scale]);
            r_py2  <= PRODW'(r_my1) * PRODW'(ldc_pkg::RECIP[r_scale]);
            r_we2  <= r_we1;
            r_wa2  <= r_wa1;
            r_wd2  <= r_wd1;
        end
    end

    // Stage 3: remove the origin and check the table bounds
    logic [PW-1:0]       w_qx, w_qy;
    logic                w_in_tab;
    assign w_qx = r_px2[ldc_pkg::RS +: PW];
    assign w_qy = r_py2[ldc_pkg::RS +: PW];
    assign w_in_tab = (32'(w_qx) >= 32'(ldc_pkg::TABLE_ORIGIN))
                   && (32'(w_qx) <  32'(ldc_pkg::TABLE_ORIGIN + TABLE_SIDE))
                   && (32'(w_qy) >= 32'(ldc_pkg::TABLE_ORIGIN))
                   && (32'(w_qy) <  32'(ldc_pkg::TABLE_ORIGIN + TABLE_SIDE));

    logic                r_op3, r_inv3, r_we3, r_tab3;
    logic [CW-1:0]       r_x3, r_y3;
    logic [SIDE_W-1:0]   r_col3, r_row3;
    logic [AW-1:0]       r_wa3;
    logic [MEM_W-1:0]    r_wd3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op3  <= r_op2;
            r_x3   <= r_x2;
            r_y3   <= r_y2;
            r_inv3 <= r_inv2;
            r_tab3 <= w_in_tab;
            r_col3 <= SIDE_W'(w_qx - PW'(ldc_pkg::TABLE_ORIGIN));
            r_row3 <= SIDE_W'(w_qy - PW'(ldc_pkg::TABLE_ORIGIN));
            r_we3  <= r_we2;
            r_wa3  <= r_wa2;
            r_wd3  <= r_wd2;
        end
    end

    // Stage 4: at most one table access per item, read or write in request order
    logic [MEM_W-1:0]    mem_table [DEPTH];
    logic [MEM_W-1:0]    r_mem_q;
    logic [AW-1:0]       w_rd_addr;
    logic                w_rd;
    assign w_rd_addr = AW'(r_row3) * AW'(TABLE_SIDE) + AW'(r_col3);
    assign w_rd      = !r_op3 && !r_inv3 && r_tab3;

    always_ff @(posedge i_clk) begin
        if (w_en && r_v3) begin
            if (r_we3) begin
                mem_table[r_wa3] <= r_wd3;
            end else if (w_rd) begin
                r_mem_q <= mem_table[w_rd_addr];
            end
        end
    end

    logic                r_op4, r_inv4, r_tab4;
    logic [CW-1:0]       r_x4, r_y4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op4  <= r_op3;
            r_x4   <= r_x3;
            r_y4   <= r_y3;
            r_inv4 <= r_inv3;
            r_tab4 <= r_tab3;
        end
    end

    // Stage 5: offsets times scale
    logic signed [OFSW-1:0] n_ox5, n_oy5, w_sc;
    logic                   r_op5, r_inv5, r_tab5;
    logic [CW-1:0]          r_x5, r_y5;
    logic signed [OFSW-1:0] r_ox5, r_oy5;

    always_comb begin
        w_sc  = $signed(OFSW'(w_scale));
        n_ox5 = $signed({{(OFSW - ldc_pkg::SHIFT_W){r_mem_q[MEM_W-1]}},
                         r_mem_q[MEM_W-1:ldc_pkg::SHIFT_W]}) * w_sc;
        n_oy5 = $signed({{(OFSW - ldc_pkg::SHIFT_W){r_mem_q[ldc_pkg::SHIFT_W-1]}},
                         r_mem_q[ldc_pkg::SHIFT_W-1:0]}) * w_sc;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op5  <= r_op4;
            r_x5   <= r_x4;
            r_y5   <= r_y4;
            r_inv5 <= r_inv4;
            r_tab5 <= r_tab4;
            r_ox5  <= n_ox5;
            r_oy5  <= n_oy5;
        end
    end

    // Stage 6: corrected point, frame check and output register
    logic signed [SUMW-1:0]          n_sx, n_sy, w_lim_x, w_lim_y;
    logic [CW-1:0]                   n_x_out, n_y_out;
    logic [ldc_pkg::OUTCOME_W-1:0]   n_outcome;

    always_comb begin
        n_sx    = $signed(SUMW'(r_x5)) + SUMW'(r_ox5);
        n_sy    = $signed(SUMW'(r_y5)) + SUMW'(r_oy5);
        w_lim_x = $signed(SUMW'({r_width, 5'b0}));
        w_lim_y = $signed(SUMW'({r_height, 5'b0}));
        n_x_out = r_x5;
        n_y_out = r_y5;
        if (r_op5) begin
            n_x_out   = '0;
            n_y_out   = '0;
            n_outcome = ldc_pkg::OUT_WRITTEN;
        end else if (r_inv5) begin
            n_outcome = ldc_pkg::OUT_INVALID;
        end else if (!r_tab5) begin
            n_outcome = ldc_pkg::OUT_TABLE;
        end else if (n_sx < 0 || n_sy < 0 || n_sx >= w_lim_x || n_sy >= w_lim_y) begin
            n_outcome = ldc_pkg::OUT_FRAME;
        end else begin
            n_x_out   = n_sx[CW-1:0];
            n_y_out   = n_sy[CW-1:0];
            n_outcome = ldc_pkg::OUT_CORRECTED;
        end
    end

    logic [CW-1:0]                   r_x_out, r_y_out;
    logic [ldc_pkg::OUTCOME_W-1:0]   r_outcome;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_out   <= n_x_out;
            r_y_out   <= n_y_out;
            r_outcome <= n_outcome;
        end
    end

    assign o_res.valid   = r_v6;
    assign o_res.x_out   = r_x_out;
    assign o_res.y_out   = r_y_out;
    assign o_res.outcome = r_outcome;

endmodule

// ----- rtl/core/ldc_checker.sv -----
// Port-level checks of the distortion correction core, bound to the core module.
// Depends on ldc_pkg and lut_distortion_correction_core_assert.svh.
`include "lut_distortion_correction_core_assert.svh"

module ldc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [ldc_pkg::COORD_W-1:0]       i_x_out,
    input  logic [ldc_pkg::COORD_W-1:0]       i_y_out,
    input  logic [ldc_pkg::OUTCOME_W-1:0]     i_outcome
);

    // Outcome stays within the defined codes
    `LDC_ASSERT_IMP(a_outcome_code, i_clk, i_rst_n, i_out_valid, i_outcome <= ldc_pkg::OUT_WRITTEN)

    // A table write answers with a zero point
    `LDC_ASSERT_IMP(a_write_zero, i_clk, i_rst_n, i_out_valid && i_outcome == ldc_pkg::OUT_WRITTEN, i_x_out == '0 && i_y_out == '0)

    // Requests are refused only behind a result that is not taken
    `LDC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // A held result keeps its value
    `LDC_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_x_out) && $stable(i_y_out) && $stable(i_outcome))

    // Reset clears the result valid flag
    `LDC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind lut_distortion_correction_core ldc_checker u_ldc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_x_out     (o_res.x_out),
    .i_y_out     (o_res.y_out),
    .i_outcome   (o_res.outcome)
);

// ----- test/testbench.sv -----
// Self-checking bench for lut_distortion_correction_core: random point and table-load
// requests with a built-in predictor. Depends on ldc_pkg, ldc_req_if, ldc_res_if and the core.
`timescale 1ns / 100ps

module testbench;

    localparam int COORD_W      = ldc_pkg::COORD_W;
    localparam int INDEX_W      = ldc_pkg::INDEX_W;
    localparam int SHIFT_W      = ldc_pkg::SHIFT_W;
    localparam int SCALE_W      = ldc_pkg::SCALE_W;
    localparam int FRAME_W      = ldc_pkg::FRAME_W;
    localparam int OUTCOME_W    = ldc_pkg::OUTCOME_W;
    localparam int CFG_IDX_W    = ldc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ldc_pkg::CFG_DATA_W;
    localparam int TABLE_ORIGIN = ldc_pkg::TABLE_ORIGIN;

    localparam int LUT_SIDE     = 512;
    localparam int LUT_DEPTH    = LUT_SIDE * LUT_SIDE;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 195;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic                      opcode;
        logic        [COORD_W-1:0] x;
        logic        [COORD_W-1:0] y;
        logic        [INDEX_W-1:0] entry;
        logic signed [SHIFT_W-1:0] xs;
        logic signed [SHIFT_W-1:0] ys;
    } t_request;

    typedef struct {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [OUTCOME_W-1:0] outcome;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ldc_req_if req_bus();
    ldc_res_if res_bus();

    lut_distortion_correction_core #(.TABLE_SIDE(LUT_SIDE)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    // Register copies used by the predictor and the request generator
    logic [SCALE_W-1:0] cfg_scale   = 5'd1;
    logic [FRAME_W-1:0] cfg_frame_w = 14'd600;
    logic [FRAME_W-1:0] cfg_frame_h = 14'd600;
    logic               cfg_check   = 1'b0;
    logic [COORD_W-1:0] cfg_marker  = '0;

    // Predictor's offset table: x offset high, y offset low
    logic [2*SHIFT_W-1:0] offset_pair [int];

    // Generator's view of which entries have been loaded so far
    int loaded_entries[$];
    bit loaded_mark [int];

    // Queues fill at the front and drain from the back
    t_request pending_requests[$];
    t_result  expected_results[$];
    t_request on_bus;

    int  outstanding = 0;
    int  error_count = 0;
    int  accepted_loads = 0;
    int  accepted_points = 0;
    int  outcome_tally [8];
    int  send_gap = 0;
    int  stall_left = 0;
    int  cycle_count = 0;
    int  settings_used = 1;
    logic calm = 1'b0;

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog and the switch between calm and gappy stretches
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 256 == 0) begin
            calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Expected result of one request; table loads update the predictor's table
    function automatic t_result predict_correction(input t_request r);
        t_result              res;
        int                   s;
        longint               col;
        longint               row;
        longint               nx;
        longint               ny;
        int                   idx;
        logic [2*SHIFT_W-1:0] pair;
        logic signed [SHIFT_W-1:0] xo;
        logic signed [SHIFT_W-1:0] yo;
        res.x = r.x;
        res.y = r.y;
        s = (cfg_scale == 0) ? 1 : int'(cfg_scale);
        if (r.opcode) begin
            if (r.entry < LUT_DEPTH) offset_pair[int'(r.entry)] = {r.xs, r.ys};
            res.x = '0;
            res.y = '0;
            res.outcome = ldc_pkg::OUT_WRITTEN;
            return res;
        end
        if (cfg_check && (r.x == cfg_marker || r.y == cfg_marker)) begin
            res.outcome = ldc_pkg::OUT_INVALID;
            return res;
        end
        // whole pixels, rounded half up, relative to the table origin
        col = (2 * longint'(r.x) + 32 * s) / (64 * s) - TABLE_ORIGIN;
        row = (2 * longint'(r.y) + 32 * s) / (64 * s) - TABLE_ORIGIN;
        if (col < 0 || col >= LUT_SIDE || row < 0 || row >= LUT_SIDE) begin
            res.outcome = ldc_pkg::OUT_TABLE;
            return res;
        end
        idx = int'(row) * LUT_SIDE + int'(col);
        pair = offset_pair.exists(idx) ? offset_pair[idx] : '0;
        xo = pair[2*SHIFT_W-1:SHIFT_W];
        yo = pair[SHIFT_W-1:0];
        nx = longint'(r.x) + longint'(xo) * s;
        ny = longint'(r.y) + longint'(yo) * s;
        if (nx < 0 || ny < 0 || nx >= longint'(cfg_frame_w) * 32
                || ny >= longint'(cfg_frame_h) * 32) begin
            res.outcome = ldc_pkg::OUT_FRAME;
            return res;
        end
        res.x = nx[COORD_W-1:0];
        res.y = ny[COORD_W-1:0];
        res.outcome = ldc_pkg::OUT_CORRECTED;
        return res;
    endfunction

    // Request driver: predicts on acceptance, then presents the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_results.push_front(predict_correction(on_bus));
                if (on_bus.opcode) accepted_loads++;
                else accepted_points++;
            end
            if (req_bus.valid && !req_bus.ready) begin
                // hold the request until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                req_bus.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                on_bus = pending_requests.pop_back();
                req_bus.opcode      <= on_bus.opcode;
                req_bus.x_in        <= on_bus.x;
                req_bus.y_in        <= on_bus.y;
                req_bus.entry_index <= on_bus.entry;
                req_bus.x_shift     <= on_bus.xs;
                req_bus.y_shift     <= on_bus.ys;
                req_bus.valid       <= 1'b1;
                send_gap = draw_gap();
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result x=%0d y=%0d outcome=%0d with nothing expected",
                        res_bus.x_out, res_bus.y_out, res_bus.outcome));
                end else begin
                    want = expected_results.pop_back();
                    outstanding--;
                    outcome_tally[want.outcome]++;
                    if (res_bus.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  res_bus.outcome, want.outcome));
                    if (res_bus.x_out !== want.x)
                        report_mismatch($sformatf("x_out %0d, expected %0d",
                                                  res_bus.x_out, want.x));
                    if (res_bus.y_out !== want.y)
                        report_mismatch($sformatf("y_out %0d, expected %0d",
                                                  res_bus.y_out, want.y));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
            end
        end
    end

    task automatic push_request(input t_request r);
        pending_requests.push_front(r);
        outstanding++;
    endtask

    // Table load; the point fields carry noise
    task automatic push_write(input int e, input logic signed [SHIFT_W-1:0] xs,
                              input logic signed [SHIFT_W-1:0] ys);
        t_request r;
        r.opcode = 1'b1;
        r.x      = COORD_W'($urandom_range(0, COORD_MAX));
        r.y      = COORD_W'($urandom_range(0, COORD_MAX));
        r.entry  = INDEX_W'(e);
        r.xs     = xs;
        r.ys     = ys;
        push_request(r);
        if (!loaded_mark.exists(e)) begin
            loaded_mark[e] = 1'b1;
            loaded_entries.push_front(e);
        end
    endtask

    // Point; the table-load fields carry noise
    task automatic push_point(input int x, input int y);
        t_request r;
        r.opcode = 1'b0;
        r.x      = COORD_W'(x);
        r.y      = COORD_W'(y);
        r.entry  = INDEX_W'($urandom_range(0, LUT_DEPTH - 1));
        r.xs     = SHIFT_W'($urandom);
        r.ys     = SHIFT_W'($urandom);
        push_request(r);
    endtask

    // Coordinate that rounds to the given whole pixel at scale s
    function automatic int coord_for_pixel(input int pix, input int s);
        return 32 * s * pix - 16 * s + $urandom_range(0, 32 * s - 1);
    endfunction

    // Coordinate whose pixel falls below or above the table
    function automatic int coord_off_table(input int s);
        if ($urandom_range(0, 1))
            return $urandom_range(0, 32 * s * TABLE_ORIGIN - 16 * s - 1);
        return $urandom_range(32 * s * (TABLE_ORIGIN + LUT_SIDE) - 16 * s, COORD_MAX);
    endfunction

    function automatic logic signed [SHIFT_W-1:0] draw_shift();
        if ($urandom_range(0, 9) < 7) return SHIFT_W'($urandom_range(0, 2000) - 1000);
        return SHIFT_W'($urandom);
    endfunction

    // One random request: loads, points off the table, marked points, points on loaded entries
    task automatic queue_random_item();
        int kind;
        int s;
        int e;
        kind = $urandom_range(0, 99);
        s = (cfg_scale == 0) ? 1 : int'(cfg_scale);
        if (kind < 25) begin
            if (loaded_entries.size() > 0 && $urandom_range(0, 3) == 0)
                e = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
            else
                e = $urandom_range(0, LUT_DEPTH - 1);
            push_write(e, draw_shift(), draw_shift());
        end else if (kind < 45) begin
            if ($urandom_range(0, 1))
                push_point(coord_off_table(s), $urandom_range(0, COORD_MAX));
            else
                push_point($urandom_range(0, COORD_MAX), coord_off_table(s));
        end else if (kind < 55 && cfg_check) begin
            if ($urandom_range(0, 1))
                push_point(int'(cfg_marker), $urandom_range(0, COORD_MAX));
            else
                push_point($urandom_range(0, COORD_MAX), int'(cfg_marker));
        end else begin
            e = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
            push_point(coord_for_pixel(e % LUT_SIDE + TABLE_ORIGIN, s),
                       coord_for_pixel(e / LUT_SIDE + TABLE_ORIGIN, s));
        end
    endtask

    task automatic wait_for_idle();
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    // Register writes happen only with the pipeline empty
    task automatic apply_settings(input int s, input int w, input int h, input int chk,
                                  input int mk);
        wait_for_idle();
        write_register(ldc_pkg::CFG_SCALE, s);
        write_register(ldc_pkg::CFG_WIDTH, w);
        write_register(ldc_pkg::CFG_HEIGHT, h);
        write_register(ldc_pkg::CFG_CHECK, chk);
        write_register(ldc_pkg::CFG_MARKER, mk);
        cfg_we <= 1'b0;
        cfg_scale   = SCALE_W'(s);
        cfg_frame_w = FRAME_W'(w);
        cfg_frame_h = FRAME_W'(h);
        cfg_check   = chk[0];
        cfg_marker  = COORD_W'(mk);
        settings_used++;
    endtask

    // Stimulus sequence
    initial begin
        int s;
        int w;
        int h;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_bus.valid = 1'b0;
        req_bus.opcode      = 1'b0;
        req_bus.x_in        = '0;
        req_bus.y_in        = '0;
        req_bus.entry_index = '0;
        req_bus.x_shift     = '0;
        req_bus.y_shift     = '0;
        res_bus.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings (scale 1, 600 x 600 frame, no marker check)
        push_write(0, 16'sh7FFF, 16'sh8000);
        push_write(LUT_DEPTH - 1, 16'sd5, -16'sd7);
        push_write(511, 16'sd1440, 16'sd0);
        push_point(1392, 1392);            // huge offsets: out of frame
        push_point(1391, 1392);            // column just below the table
        push_point(1392, 1391);            // row just below the table
        push_point(0, 0);
        push_point(COORD_MAX, COORD_MAX);
        push_point(17775, 17775);          // last table entry, corrected
        push_point(17776, 17760);          // column just past the table
        push_point(1392, 17776);           // row just past the table
        push_point(17760, 1392);           // corrected x lands exactly on the frame edge
        push_write(511, 16'sd1439, -16'sd1392);
        push_point(17760, 1392);           // last pixel inside, y lands on zero
        push_write(511, 16'sd0, -16'sd1393);
        push_point(17760, 1392);           // y goes negative
        push_write(0, 16'sd0, 16'sd0);
        push_point(1423, 1423);            // zero offset: point passes corrected as is

        // Random phases; the first three hit the register extremes
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: apply_settings(16, 16383, 16383, 1, 0);
                1: apply_settings(0, 1, 16383, 1, COORD_MAX);
                2: apply_settings(1, 16383, 1, 0, $urandom_range(0, COORD_MAX));
                default: begin
                    s = $urandom_range(1, 16);
                    w = $urandom_range(s * 400, 16383);
                    h = $urandom_range(s * 400, 16383);
                    apply_settings(s, w, h, $urandom_range(0, 1),
                                   $urandom_range(0, COORD_MAX));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until the pipeline has drained
                if (ph == 4 && n == PHASE_ITEMS / 2) wait_for_idle();
                queue_random_item();
            end
        end

        wait_for_idle();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d table loads and %0d points over %0d register settings",
                 accepted_loads, accepted_points, settings_used);
        $display("outcomes: corrected %0d, out of frame %0d, off table %0d, skipped %0d",
                 outcome_tally[ldc_pkg::OUT_CORRECTED], outcome_tally[ldc_pkg::OUT_FRAME],
                 outcome_tally[ldc_pkg::OUT_TABLE], outcome_tally[ldc_pkg::OUT_INVALID]);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
